@@ rtl/jhe_pkg.sv @@
// ----------------------------------------------------------------------------
// jhe_pkg
// shared types, codes and helper functions of the jpeg huffman block encoder
// ----------------------------------------------------------------------------
package jhe_pkg;

  typedef enum logic [1:0] {
    CMD_COEF  = 2'd0,
    CMD_FLUSH = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  localparam int unsigned SymW     = 8;
  localparam int unsigned TabW     = 2;
  localparam int unsigned AddrW    = TabW + SymW;
  localparam int unsigned CodeW    = 16;
  localparam int unsigned LenW     = 5;
  localparam int unsigned PosW     = 6;
  localparam int unsigned BlockCoefs = 64;

  localparam logic [SymW-1:0] ZRL_SYM    = 8'hF0;
  localparam logic [SymW-1:0] EOB_SYM    = 8'h00;
  localparam logic [7:0]      FF_BYTE    = 8'hFF;
  localparam logic [7:0]      STUFF_BYTE = 8'h00;
  localparam logic [7:0]      EOI_BYTE   = 8'hD9;
  localparam logic [TabW-1:0] TAB_LUMA_AC = 2'd1;
  localparam logic [LenW-1:0] MAX_LEN    = 5'd16;

  typedef struct packed {
    logic [LenW-1:0]  len;
    logic [CodeW-1:0] code;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    entry_t           data;
  } mem_wr_t;

  // number of significant bits of a magnitude
  function automatic logic [3:0] size_of(input logic [10:0] mag);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 11; i++) begin
      if (mag[i]) n = 4'(i + 1);
    end
    return n;
  endfunction

endpackage

@@ rtl/jhe_in_if.sv @@
// ----------------------------------------------------------------------------
// jhe_in_if
// request channel into the encoder: command, coefficient and table load fields
// ----------------------------------------------------------------------------
interface jhe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic signed [11:0] coefficient;
  logic        component;
  logic [1:0]  table_sel;
  logic [7:0]  symbol;
  logic [4:0]  code_length;
  logic        table_start;

  modport source (output valid, cmd, coefficient, component, table_sel, symbol,
                  code_length, table_start, input ready);
  modport sink   (input valid, cmd, coefficient, component, table_sel, symbol,
                  code_length, table_start, output ready);
endinterface

@@ rtl/jhe_out_if.sv @@
// ----------------------------------------------------------------------------
// jhe_out_if
// byte channel out of the encoder
// ----------------------------------------------------------------------------
interface jhe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

@@ rtl/jhe_code_mem.sv @@
// ----------------------------------------------------------------------------
// jhe_code_mem
// code table store: one write port, one registered read port
// ----------------------------------------------------------------------------
module jhe_code_mem (
  input  logic                      clk_i,
  input  jhe_pkg::mem_wr_t          wr_i,
  input  logic                      rd_en_i,
  input  logic [jhe_pkg::AddrW-1:0] rd_addr_i,
  output jhe_pkg::entry_t           rd_data_o
);
  import jhe_pkg::*;

  entry_t mem [2**AddrW];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;
endmodule

@@ rtl/jpeg_huffman_block_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// jpeg_huffman_block_encoder_unit
// baseline jpeg entropy coder: huffman symbols, magnitude bits, byte stuffing
// ----------------------------------------------------------------------------
// sequence: a coefficient runs its zrl lookups, its symbol lookup, its magnitude
//   push and its eob lookup in turn, each followed by draining the output bytes
// throughput: one request at a time, set by the single read port of the code
//   store and the one-byte-per-cycle packer, which holds while the output stalls;
//   a load with table_start first wipes that table
// reset: asynchronous, active low; then a clearing pass over the whole code
//   store during which no request is taken
module jpeg_huffman_block_encoder_unit (
  input  logic clk_i,
  input  logic rst_ni,
  jhe_in_if.sink    in_i,
  jhe_out_if.source out_o
);
  import jhe_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_NEXT  = 10'b0000000100,
    S_SYM   = 10'b0000001000,
    S_DRAIN = 10'b0000010000,
    S_FF    = 10'b0000100000,
    S_D9    = 10'b0001000000,
    S_FIN   = 10'b0010000000,
    S_WIPE  = 10'b0100000000,
    S_LOAD  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // block and load state
  logic [PosW-1:0]  pos_q, pos_d;
  logic [PosW-1:0]  zr_q, zr_d;
  logic             comp_q, comp_d;
  logic [16:0]      lcode_q, lcode_d;
  logic [LenW-1:0]  llen_q, llen_d;

  // bit packer
  logic [23:0]      acc_q, acc_d;
  logic [4:0]       cnt_q, cnt_d;
  logic             stuff_q, stuff_d;

  // per-request work list
  logic [TabW-1:0]  tab_q, tab_d;
  logic [1:0]       rep_q, rep_d;
  logic [SymW-1:0]  rep_sym_q, rep_sym_d;
  logic             main_q, main_d;
  logic [SymW-1:0]  main_sym_q, main_sym_d;
  logic             bits_q, bits_d;
  logic [10:0]      mbits_q, mbits_d;
  logic [3:0]       nb_q, nb_d;
  logic             eob_q, eob_d;
  logic             mark_q, mark_d;

  // table load request
  logic [TabW-1:0]  ld_sel_q, ld_sel_d;
  logic [SymW-1:0]  ld_sym_q, ld_sym_d;
  logic [LenW-1:0]  ld_len_q, ld_len_d;
  logic [AddrW-1:0] sweep_q, sweep_d;

  // one-byte hold so the final byte of a request can be marked last
  logic             hold_v_q, hold_v_d;
  logic [7:0]       hold_q, hold_d;
  logic             out_v_q, out_v_d;
  logic [7:0]       out_b_q, out_b_d;
  logic             out_l_q, out_l_d;

  mem_wr_t          wr;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  entry_t           rd_data;

  jhe_code_mem u_mem (
    .clk_i    (clk_i),
    .wr_i     (wr),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // coefficient decode
  logic        c_neg;
  logic [11:0] c_mag12;
  logic [10:0] c_mag;
  logic [10:0] c_bits;
  logic [3:0]  c_nb;

  always_comb begin
    c_neg   = in_i.coefficient[11];
    c_mag12 = c_neg ? 12'(~in_i.coefficient + 12'sd1) : in_i.coefficient;
    c_mag   = c_mag12[11] ? 11'h7FF : c_mag12[10:0];
    c_bits  = c_neg ? ~c_mag : c_mag;
    c_nb    = size_of(c_mag);
  end

  // append size bits of code to the accumulator
  function automatic logic [23:0] push_acc(input logic [23:0] acc,
                                           input logic [4:0] cnt,
                                           input logic [15:0] code,
                                           input logic [4:0] size);
    logic [15:0] masked;
    logic [4:0]  n;
    logic [4:0]  sh;
    logic [39:0] tmp;
    masked = code & 16'((17'd1 << size) - 17'd1);
    n      = cnt + size;
    sh     = 5'(5'd24 - n);
    tmp    = {24'd0, masked} << sh;
    return acc | tmp[23:0];
  endfunction

  logic       out_free, can_emit, emit, release_last;
  logic [7:0] emit_data;
  logic [4:0] psize;
  logic [16:0] code_inc;
  logic [16:0] code_new;

  assign out_free = !out_v_q || out_o.ready;
  assign can_emit = !hold_v_q || out_free;
  assign psize    = (rd_data.len > MAX_LEN) ? MAX_LEN : rd_data.len;
  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    pos_d = pos_q;  zr_d = zr_q;  comp_d = comp_q;
    lcode_d = lcode_q;  llen_d = llen_q;
    acc_d = acc_q;  cnt_d = cnt_q;  stuff_d = stuff_q;
    tab_d = tab_q;  rep_d = rep_q;  rep_sym_d = rep_sym_q;
    main_d = main_q;  main_sym_d = main_sym_q;
    bits_d = bits_q;  mbits_d = mbits_q;  nb_d = nb_q;
    eob_d = eob_q;  mark_d = mark_q;
    ld_sel_d = ld_sel_q;  ld_sym_d = ld_sym_q;  ld_len_d = ld_len_q;
    sweep_d = sweep_q;
    emit = 1'b0;  emit_data = STUFF_BYTE;  release_last = 1'b0;
    rd_en = 1'b0;  rd_addr = {tab_q, EOB_SYM};
    wr = '0;
    code_inc = 17'(lcode_q + 17'd1);
    code_new = 17'd0;

    unique case (state_q)
      S_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = sweep_q;
        sweep_d = sweep_q + 1'b1;
        if (&sweep_q) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_i.valid) begin
          unique case (cmd_e'(in_i.cmd))
            CMD_COEF: begin
              mark_d = 1'b0;
              mbits_d = c_bits;
              nb_d = c_nb;
              if (pos_q == '0) begin
                comp_d = in_i.component;
                tab_d = {in_i.component, 1'b0};
                rep_d = 2'd0;
                main_d = 1'b1;
                main_sym_d = {4'd0, c_nb};
                bits_d = (c_nb != 4'd0);
                eob_d = 1'b0;
                zr_d = '0;
              end else begin
                tab_d = {comp_q, 1'b1};
                rep_sym_d = ZRL_SYM;
                main_sym_d = {zr_q[3:0], c_nb};
                if (c_mag != '0) begin
                  rep_d = zr_q[5:4];
                  main_d = 1'b1;
                  bits_d = 1'b1;
                  eob_d = 1'b0;
                  zr_d = '0;
                end else begin
                  rep_d = 2'd0;
                  main_d = 1'b0;
                  bits_d = 1'b0;
                  eob_d = (pos_q == PosW'(BlockCoefs - 1));
                  zr_d = zr_q + 1'b1;
                end
              end
              if (pos_q == PosW'(BlockCoefs - 1)) begin
                pos_d = '0;
                zr_d = '0;
              end else begin
                pos_d = pos_q + 1'b1;
              end
              state_d = S_NEXT;
            end
            CMD_FLUSH: begin
              // pad with two luma eob codes only when bits are pending
              tab_d = TAB_LUMA_AC;
              rep_sym_d = EOB_SYM;
              rep_d = (cnt_q != '0) ? 2'd2 : 2'd0;
              main_d = 1'b0;  bits_d = 1'b0;  eob_d = 1'b0;  mark_d = 1'b1;
              pos_d = '0;  zr_d = '0;
              state_d = S_NEXT;
            end
            CMD_LOAD: begin
              if (in_i.code_length != '0) begin
                ld_sel_d = in_i.table_sel;
                ld_sym_d = in_i.symbol;
                ld_len_d = (in_i.code_length > MAX_LEN) ? MAX_LEN : in_i.code_length;
                sweep_d = '0;
                state_d = in_i.table_start ? S_WIPE : S_LOAD;
              end
            end
            default: ;
          endcase
        end
      end
      S_NEXT: begin
        priority if (rep_q != 2'd0) begin
          rd_en = 1'b1;  rd_addr = {tab_q, rep_sym_q};
          rep_d = rep_q - 1'b1;
          state_d = S_SYM;
        end else if (main_q) begin
          rd_en = 1'b1;  rd_addr = {tab_q, main_sym_q};
          main_d = 1'b0;
          state_d = S_SYM;
        end else if (bits_q) begin
          acc_d = push_acc(acc_q, cnt_q, {5'd0, mbits_q}, {1'b0, nb_q});
          cnt_d = cnt_q + {1'b0, nb_q};
          bits_d = 1'b0;
          state_d = S_DRAIN;
        end else if (eob_q) begin
          rd_en = 1'b1;  rd_addr = {tab_q, EOB_SYM};
          eob_d = 1'b0;
          state_d = S_SYM;
        end else if (mark_q) begin
          // leftover bits are dropped before the end marker
          acc_d = '0;  cnt_d = '0;  mark_d = 1'b0;
          state_d = S_FF;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SYM: begin
        acc_d = push_acc(acc_q, cnt_q, rd_data.code, psize);
        cnt_d = cnt_q + psize;
        state_d = S_DRAIN;
      end
      S_DRAIN: begin
        priority if (stuff_q) begin
          if (can_emit) begin
            emit = 1'b1;  emit_data = STUFF_BYTE;  stuff_d = 1'b0;
          end
        end else if (cnt_q >= 5'd8) begin
          if (can_emit) begin
            emit = 1'b1;  emit_data = acc_q[23:16];
            stuff_d = (acc_q[23:16] == FF_BYTE);
            acc_d = {acc_q[15:0], 8'd0};
            cnt_d = cnt_q - 5'd8;
          end
        end else begin
          state_d = S_NEXT;
        end
      end
      S_FF: begin
        if (can_emit) begin
          emit = 1'b1;  emit_data = FF_BYTE;  state_d = S_D9;
        end
      end
      S_D9: begin
        if (can_emit) begin
          emit = 1'b1;  emit_data = EOI_BYTE;  state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!hold_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          release_last = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_WIPE: begin
        // table_start clears the lengths of the selected table
        wr.en   = 1'b1;
        wr.addr = {ld_sel_q, sweep_q[SymW-1:0]};
        sweep_d = sweep_q + 1'b1;
        if (&sweep_q[SymW-1:0]) state_d = S_LOAD;
      end
      S_LOAD: begin
        if (sweep_q[SymW]) begin
          code_new = 17'd0;
        end else if (ld_len_q > llen_q) begin
          code_new = code_inc << 5'(ld_len_q - llen_q);
        end else begin
          code_new = code_inc;
        end
        lcode_d = code_new;
        llen_d = ld_len_q;
        wr.en = 1'b1;
        wr.addr = {ld_sel_q, ld_sym_q};
        wr.data.len = ld_len_q;
        wr.data.code = code_new[15:0] & 16'((17'd1 << ld_len_q) - 17'd1);
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output side: hold stage feeds the output register
  always_comb begin
    hold_v_d = hold_v_q;  hold_d = hold_q;
    out_v_d = out_v_q;  out_b_d = out_b_q;  out_l_d = out_l_q;
    if (out_v_q && out_o.ready) out_v_d = 1'b0;
    if (emit) begin
      if (hold_v_q) begin
        out_v_d = 1'b1;  out_b_d = hold_q;  out_l_d = 1'b0;
      end
      hold_v_d = 1'b1;
      hold_d = emit_data;
    end else if (release_last) begin
      out_v_d = 1'b1;  out_b_d = hold_q;  out_l_d = 1'b1;
      hold_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      pos_q <= '0;  zr_q <= '0;  comp_q <= 1'b0;
      lcode_q <= '0;  llen_q <= '0;
      acc_q <= '0;  cnt_q <= '0;  stuff_q <= 1'b0;
      rep_q <= '0;  main_q <= 1'b0;  bits_q <= 1'b0;  eob_q <= 1'b0;  mark_q <= 1'b0;
      sweep_q <= '0;
      hold_v_q <= 1'b0;  out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q <= pos_d;  zr_q <= zr_d;  comp_q <= comp_d;
      lcode_q <= lcode_d;  llen_q <= llen_d;
      acc_q <= acc_d;  cnt_q <= cnt_d;  stuff_q <= stuff_d;
      rep_q <= rep_d;  main_q <= main_d;  bits_q <= bits_d;  eob_q <= eob_d;
      mark_q <= mark_d;
      sweep_q <= sweep_d;
      hold_v_q <= hold_v_d;  out_v_q <= out_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tab_q <= tab_d;  rep_sym_q <= rep_sym_d;  main_sym_q <= main_sym_d;
    mbits_q <= mbits_d;  nb_q <= nb_d;
    ld_sel_q <= ld_sel_d;  ld_sym_q <= ld_sym_d;  ld_len_q <= ld_len_d;
    hold_q <= hold_d;  out_b_q <= out_b_d;  out_l_q <= out_l_d;
  end

  assign out_o.valid     = out_v_q;
  assign out_o.out_byte  = out_b_q;
  assign out_o.last_byte = out_l_q;

  // packer holds less than a byte and no stuff byte, and the hold stage is empty, between requests
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (cnt_q < 5'd8 && !stuff_q && !hold_v_q))
    else $error("packer not drained at idle");

  // a symbol push always follows its store read
  a_sym_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SYM) |-> $past(state_q == S_NEXT && rd_en))
    else $error("symbol push without store read");

  // releasing the final byte of a request marks it last and empties the hold stage
  a_last_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    release_last |=> (out_v_q && out_l_q && !hold_v_q))
    else $error("last byte release lost");
endmodule

@@ tb/jpeg_huffman_block_encoder_unit_test.sv @@
// ----------------------------------------------------------------------------
// jpeg_huffman_block_encoder_unit_test
// drives loads, coefficients and flushes into the entropy coder and checks
// every output byte against a behavioral copy of the huffman packer or literal typed bytes
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module jpeg_huffman_block_encoder_unit_test;
  import jhe_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned HoldCycles = 300;

  typedef struct {
    cmd_e        cmd;
    logic [11:0] coefficient;
    logic        component;
    logic [1:0]  table_sel;
    logic [7:0]  symbol;
    logic [4:0]  code_length;
    logic        table_start;
  } request_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  // one row of the directed table; typed rows carry their bytes literally
  typedef struct {
    request_t   req;
    bit         typed;
    int         n_typed;
    logic [7:0] typed_bytes [2];
  } stim_row_t;

  logic clk;
  logic rst_n;

  jhe_in_if  in_ch ();
  jhe_out_if out_ch ();

  jpeg_huffman_block_encoder_unit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // ---------------------------------------------------------------------------
  // behavioral copy of the encoder state
  // ---------------------------------------------------------------------------
  logic [CodeW-1:0] huff_code [1024];
  logic [LenW-1:0]  huff_len  [1024];
  logic [23:0]      bit_acc;
  int unsigned      bit_cnt;
  int unsigned      coef_pos;
  int unsigned      zeros_seen;
  logic             blk_chroma;
  logic [16:0]      next_code;
  int unsigned      next_len;

  logic [7:0]   step_bytes [$];   // bytes caused by the request being predicted
  stream_byte_t stream_q [$];     // bytes still owed by the dut

  int unsigned mismatches;
  int unsigned n_items;
  bit          calm;              // no idling on either side
  bit          hold_req;

  function automatic void pack_bits(int unsigned code, int unsigned size);
    int unsigned acc;
    int unsigned b;
    acc = bit_acc;
    if (size > 16) size = 16;
    if (size > 0) begin
      code = code & ((1 << size) - 1);
      bit_cnt += size;
      acc = acc | (code << (24 - bit_cnt));
    end
    while (bit_cnt >= 8) begin
      b = (acc >> 16) & 8'hFF;
      step_bytes.push_back(b[7:0]);
      // marker escape
      if (b[7:0] == FF_BYTE) step_bytes.push_back(STUFF_BYTE);
      acc = (acc << 8) & 24'hFFFFFF;
      bit_cnt -= 8;
    end
    bit_acc = acc[23:0];
  endfunction

  function automatic void pack_symbol(int unsigned tab, logic [7:0] sym);
    int unsigned idx;
    idx = (tab & 3) * 256 + sym;
    pack_bits(huff_code[idx], huff_len[idx]);
  endfunction

  function automatic void load_table_symbol(request_t r);
    int unsigned len;
    int unsigned code;
    int unsigned idx;
    len = r.code_length;
    if (len == 0) return;   // zero length: whole load ignored
    if (len > 16) len = 16;
    if (r.table_start) begin
      for (int i = 0; i < 256; i++) huff_len[r.table_sel * 256 + i] = '0;
      code = 0;
    end else begin
      code = (next_code + 1) & 17'h1FFFF;
      if (len > next_len) code = (code << (len - next_len)) & 17'h1FFFF;
    end
    next_code = code[16:0];
    next_len  = len;
    idx = r.table_sel * 256 + r.symbol;
    huff_code[idx] = CodeW'(code & ((1 << len) - 1));
    huff_len[idx]  = len[4:0];
  endfunction

  function automatic void encode_coefficient(request_t r);
    int unsigned mag;
    int unsigned mag_bits;
    int unsigned cat;
    int unsigned tab;
    mag = r.coefficient[11] ? ((4096 - r.coefficient) & 12'hFFF) : r.coefficient;
    if (mag > 2047) mag = 2047;   // -2048 saturates
    mag_bits = r.coefficient[11] ? ((0 - mag - 1) & 11'h7FF) : mag;
    cat = 0;
    for (int i = 0; i < 11; i++) if ((mag >> i) & 1) cat = i + 1;
    if (coef_pos == 0) begin
      // dc: component latched for the block
      blk_chroma = r.component;
      tab = blk_chroma * 2;
      pack_symbol(tab, cat[7:0]);
      if (cat > 0) pack_bits(mag_bits, cat);
      zeros_seen = 0;
    end else begin
      tab = blk_chroma * 2 + 1;
      if (mag == 0) begin
        zeros_seen++;
      end else begin
        while (zeros_seen > 15) begin
          pack_symbol(tab, ZRL_SYM);
          zeros_seen -= 16;
        end
        pack_symbol(tab, 8'((zeros_seen << 4) + cat));
        pack_bits(mag_bits, cat);
        zeros_seen = 0;
      end
      // trailing zeros close with end of block
      if (coef_pos == BlockCoefs - 1 && zeros_seen > 0) pack_symbol(tab, EOB_SYM);
    end
    if (coef_pos >= BlockCoefs - 1) begin
      coef_pos   = 0;
      zeros_seen = 0;
    end else begin
      coef_pos++;
    end
  endfunction

  // works out the bytes of one accepted request into step_bytes
  function automatic void predict_bytes(request_t r);
    step_bytes.delete();
    case (r.cmd)
      CMD_COEF: begin
        encode_coefficient(r);
      end
      CMD_FLUSH: begin
        // pad with two luma ac eob codes only if bits are pending
        if (bit_cnt > 0) begin
          pack_symbol(TAB_LUMA_AC, EOB_SYM);
          pack_symbol(TAB_LUMA_AC, EOB_SYM);
        end
        bit_acc    = '0;
        bit_cnt    = 0;
        coef_pos   = 0;
        zeros_seen = 0;
        step_bytes.push_back(FF_BYTE);
        step_bytes.push_back(EOI_BYTE);
      end
      CMD_LOAD: begin
        load_table_symbol(r);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void queue_bytes();
    stream_byte_t sb;
    foreach (step_bytes[i]) begin
      sb.data = step_bytes[i];
      sb.last = (i == step_bytes.size() - 1);
      stream_q.push_back(sb);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // clock, reset, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // byte sink: random back-pressure plus one long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold_cnt;
    hold_cnt = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HoldCycles;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= 30);
      end
    end
  end

  // compare each accepted byte with the oldest owed one
  always @(posedge clk) begin
    stream_byte_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (stream_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected byte %02h last %0b", out_ch.out_byte, out_ch.last_byte);
      end else begin
        want = stream_q.pop_front();
        if (out_ch.out_byte !== want.data || out_ch.last_byte !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                     want.data, want.last, out_ch.out_byte, out_ch.last_byte);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request source
  // ---------------------------------------------------------------------------
  // offers one request, idling at random first, and returns once accepted
  task automatic send_request(request_t r, bit typed = 1'b0);
    while (!calm && $urandom_range(0, 99) < 30) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= r.cmd;
    in_ch.coefficient <= r.coefficient;
    in_ch.component   <= r.component;
    in_ch.table_sel   <= r.table_sel;
    in_ch.symbol      <= r.symbol;
    in_ch.code_length <= r.code_length;
    in_ch.table_start <= r.table_start;
    @(posedge clk);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
    predict_bytes(r);
    if (!typed) queue_bytes();
    n_items++;
  endtask

  function automatic request_t make_req(cmd_e c);
    request_t r;
    r.cmd         = c;
    r.coefficient = 12'($urandom);
    r.component   = 1'($urandom);
    r.table_sel   = 2'($urandom);
    r.symbol      = 8'($urandom);
    r.code_length = 5'($urandom);
    r.table_start = 1'b0;
    return r;
  endfunction

  function automatic request_t coef_req(logic [11:0] v, logic comp);
    request_t r;
    r = make_req(CMD_COEF);
    r.coefficient = v;
    r.component   = comp;
    return r;
  endfunction

  function automatic request_t load_req(logic [1:0] sel, logic [7:0] sym,
                                        logic [4:0] len, logic start);
    request_t r;
    r = make_req(CMD_LOAD);
    r.table_sel   = sel;
    r.symbol      = sym;
    r.code_length = len;
    r.table_start = start;
    return r;
  endfunction

  // symbol worth loading: zrl, eob, a plausible run/size, or anything
  function automatic logic [7:0] pick_symbol(logic [1:0] sel);
    case ($urandom_range(0, 9))
      0:       return ZRL_SYM;
      1:       return EOB_SYM;
      2:       return 8'($urandom);
      default: return sel[0] ? 8'(($urandom_range(0, 15) << 4) | $urandom_range(1, 11))
                             : 8'($urandom_range(0, 11));
    endcase
  endfunction

  // coefficient with a random size category, mostly zero
  function automatic logic [11:0] pick_coefficient();
    int unsigned k;
    int unsigned m;
    if ($urandom_range(0, 99) < 70) return '0;
    if ($urandom_range(0, 9) == 0) return 12'($urandom);
    k = $urandom_range(1, 11);
    m = $urandom_range(1 << (k - 1), (1 << k) - 1);
    return $urandom_range(0, 1) ? 12'(-m) : 12'(m);
  endfunction

  stim_row_t directed [$];

  function automatic void add_row(request_t r, int n = -1,
                                  logic [7:0] b0 = 8'h00, logic [7:0] b1 = 8'h00);
    stim_row_t row;
    row.req            = r;
    row.typed          = (n >= 0);
    row.n_typed        = (n < 0) ? 0 : n;
    row.typed_bytes[0] = b0;
    row.typed_bytes[1] = b1;
    directed.push_back(row);
  endfunction

  initial begin
    request_t r;
    stream_byte_t sb;
    int unsigned len;
    int unsigned cnt;
    int unsigned burst;
    logic [1:0] sel;
    bit held_off;
    bit paused;

    mismatches = 0;
    n_items    = 0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    held_off   = 1'b0;
    paused     = 1'b0;
    for (int i = 0; i < 1024; i++) begin
      huff_code[i] = '0;
      huff_len[i]  = '0;
    end
    bit_acc = '0; bit_cnt = 0; coef_pos = 0; zeros_seen = 0;
    blk_chroma = 1'b0; next_code = '0; next_len = 0;

    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= CMD_NONE;
    in_ch.coefficient <= '0;
    in_ch.component   <= 1'b0;
    in_ch.table_sel   <= '0;
    in_ch.symbol      <= '0;
    in_ch.code_length <= '0;
    in_ch.table_start <= 1'b0;

    // directed table
    add_row(make_req(CMD_FLUSH), 2, FF_BYTE, EOI_BYTE);   // flush with nothing pending
    add_row(make_req(CMD_NONE), 0);                        // unused command
    add_row(load_req(2'd0, 8'd0, 5'd0, 1'b1), 0);          // zero length ignored
    add_row(coef_req(12'sd2047, 1'b0));                    // no tables yet: bits only
    add_row(coef_req(12'h800, 1'b1));                      // -2048 saturates
    add_row(make_req(CMD_FLUSH));
    add_row(load_req(2'd0, 8'd0, 5'd2, 1'b1));
    add_row(load_req(2'd0, 8'd11, 5'd3, 1'b0));
    add_row(load_req(2'd0, 8'd1, 5'd3, 1'b0));
    add_row(load_req(2'd0, 8'd3, 5'd2, 1'b0));             // decreasing length
    add_row(load_req(2'd0, 8'd4, 5'd31, 1'b0));            // length above 16
    add_row(load_req(2'd1, 8'h00, 5'd4, 1'b1));
    add_row(load_req(2'd1, ZRL_SYM, 5'd16, 1'b0));
    add_row(load_req(2'd1, 8'h01, 5'd16, 1'b0));           // same length: code plus one
    add_row(load_req(2'd1, 8'hFF, 5'd16, 1'b0));
    add_row(coef_req(12'sd2047, 1'b0));
    add_row(coef_req(12'h801, 1'b1));                      // -2047, component ignored
    add_row(coef_req(12'd0, 1'b0));
    add_row(coef_req(12'd1, 1'b0));
    add_row(coef_req(12'hFFF, 1'b0));
    add_row(make_req(CMD_FLUSH));
    add_row(make_req(CMD_FLUSH), 2, FF_BYTE, EOI_BYTE);    // flush right after flush

    // start driving at a clock edge once reset is released
    wait (rst_n);
    @(posedge clk);

    foreach (directed[i]) begin
      send_request(directed[i].req, directed[i].typed);
      for (int k = 0; k < directed[i].n_typed; k++) begin
        sb.data = directed[i].typed_bytes[k];
        sb.last = (k == directed[i].n_typed - 1);
        stream_q.push_back(sb);
      end
    end

    // random part: table loads, coefficient runs, flushes and noise
    while (n_items < 170) begin
      calm = (n_items >= 60 && n_items < 100);
      if (n_items >= 120 && !held_off) begin
        held_off = 1'b1;
        hold_req = 1'b1;
      end
      if (n_items >= 140 && !paused) begin
        // sender pauses until the stream has drained
        paused = 1'b1;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (stream_q.size() != 0) @(posedge clk);
      end
      case ($urandom_range(0, 19))
        0, 1: begin
          send_request(make_req(CMD_FLUSH));
        end
        2: begin
          // noise: unused command or zero-length load
          if ($urandom_range(0, 1)) begin
            send_request(make_req(CMD_NONE));
          end else begin
            r = make_req(CMD_LOAD);
            r.code_length = '0;
            send_request(r);
          end
        end
        3, 4, 5, 6: begin
          // one table load with nondecreasing lengths, rarely broken
          sel = 2'($urandom);
          len = $urandom_range(1, 6);
          cnt = $urandom_range(3, 10);
          for (int k = 0; k < cnt; k++) begin
            r = load_req(sel, pick_symbol(sel), 5'(len), k == 0);
            if ($urandom_range(0, 19) == 0) r.code_length = 5'($urandom_range(17, 31));
            send_request(r);
            if ($urandom_range(0, 19) == 0) len = $urandom_range(1, 16);
            else len = (len + $urandom_range(0, 2) > 16) ? 16 : len + $urandom_range(0, 2);
          end
        end
        default: begin
          burst = $urandom_range(8, 40);
          for (int k = 0; k < burst; k++)
            send_request(coef_req(pick_coefficient(), 1'($urandom)));
        end
      endcase
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    while (stream_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && stream_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
